// ----- hdl/srf_pkg.sv -----
// Shared types, codes and sizes of the stream receive reassembly block.
package srf_pkg;

  // Ring depth in bytes; must be a power of two (positions wrap by truncation).
  localparam int unsigned RingBytes = 4096;
  localparam int unsigned RingAw    = $clog2(RingBytes);
  localparam int unsigned RingDw    = 9;  // present bit + byte

  localparam int unsigned OffW = 64;

  localparam logic [1:0] OpHeader = 2'd0;
  localparam logic [1:0] OpData   = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpReset  = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StIgnored   = 3'd1;
  localparam logic [2:0] StFinalSize = 3'd2;
  localparam logic [2:0] StFlow      = 3'd3;
  localparam logic [2:0] StNoData    = 3'd4;
  localparam logic [2:0] StEnd       = 3'd5;
  localparam logic [2:0] StReset     = 3'd6;

  localparam logic [12:0] StreamWindowRst = 13'd4096;
  localparam logic [20:0] ConnWindowRst   = 21'd65536;

  localparam logic [2:0] AddrStreamWindow = 3'd0;
  localparam logic [2:0] AddrConnWindow   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [61:0] offset;
    logic [15:0] length;
    logic        fin;
    logic [7:0]  data_byte;
    logic [61:0] error_code;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [61:0] app_error;
    logic [61:0] stream_limit;
    logic        stream_limit_raised;
    logic [61:0] conn_limit_out;
    logic        conn_limit_raised;
  } result_t;

  typedef struct packed {
    logic [12:0] stream_window;
    logic [20:0] conn_window;
  } win_t;

endpackage

// ----- hdl/srf_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module srf_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/srf_cfg.sv -----
// APB register file holding the stream and connection credit windows.
module srf_cfg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output srf_pkg::win_t win_o
);

  logic [12:0] sw_q;
  logic [20:0] cw_q;
  logic        wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= srf_pkg::StreamWindowRst;
      cw_q <= srf_pkg::ConnWindowRst;
    end else if (wr) begin
      case (paddr)
        srf_pkg::AddrStreamWindow: sw_q <= pwdata[12:0];
        srf_pkg::AddrConnWindow:   cw_q <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      srf_pkg::AddrStreamWindow: prdata = {19'd0, sw_q};
      srf_pkg::AddrConnWindow:   prdata = {11'd0, cw_q};
      default:                   prdata = 32'd0;
    endcase
  end

  assign win_o = '{stream_window: sw_q, conn_window: cw_q};

endmodule

// ----- hdl/stream_rx_reassembly_flow_control.sv -----
// Top level: QUIC stream receive reassembly with stream and connection flow control.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------
//  item     | in        | start_i && !busy_o      | item_i  (item_t)
//  result   | out       | res_valid_o, one cycle  | res_o   (result_t)
//  config   | in        | APB write, pready high  | paddr/pwdata
//
// Each item passes through accept (ring RAM read issued), calc (frame end and
// ring-relative offset), exec (checks, ring write-back) and credit (limit raise);
// the result strobe follows in the next cycle, in which a new item may start.
// The ring RAM has a single port pair: an item reads one entry and may write it back.
// After reset the ring's present bits are cleared, one entry per cycle, over all
// RingBytes (4096) entries with busy_o high; config writes are taken meanwhile.
// The receiver cannot stall; results are never held back.
module stream_rx_reassembly_flow_control (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  srf_pkg::item_t   item_i,
  output logic             res_valid_o,
  output srf_pkg::result_t res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned Aw = srf_pkg::RingAw;
  localparam int unsigned W  = srf_pkg::OffW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_CREDIT = 3'd4;

  srf_pkg::win_t win;

  srf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .win_o (win)
  );

  // ---------------------------------------------------------------- state
  logic [2:0]    state_q, state_d;
  logic [Aw-1:0] clr_q;
  srf_pkg::item_t it_q;
  logic [Aw-1:0] pos_q;             // ring entry addressed by this item
  logic [W-1:0]  end_q;             // frame end / reset size
  logic          off_lt_rd_q;       // offset below read offset
  logic          rel_big_q;         // offset at least a ring past read offset

  logic [W-1:0]  rd_off_q, rd_off_d;
  logic [Aw-1:0] rd_pos_q, rd_pos_d;
  logic [W-1:0]  high_q, high_d;
  logic [W-1:0]  fsize_q, fsize_d;
  logic          fknown_q, fknown_d;
  logic [W-1:0]  s_cred_q, s_cred_d;
  logic [W-1:0]  c_cred_q, c_cred_d;
  logic          rst_seen_q, rst_seen_d;
  logic          done_q, done_d;
  logic [61:0]   perr_q, perr_d;
  logic          fopen_q, fopen_d;
  logic [W-1:0]  fend_q, fend_d;

  logic [2:0]    st_q, st_d;
  logic [7:0]    rbyte_q, rbyte_d;
  logic [61:0]   aerr_q, aerr_d;
  logic          raise_q, raise_d;  // credit update wanted
  logic          with_s_q, with_s_d;

  logic          valid_q;
  srf_pkg::result_t res_q;

  // ------------------------------------------------------------ ring RAM
  logic                    we, re;
  logic [Aw-1:0]           waddr, raddr;
  logic [srf_pkg::RingDw-1:0] wdata, rdata;

  srf_ram #(.Width(srf_pkg::RingDw), .Depth(srf_pkg::RingBytes)) u_ring (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic accept;
  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // data spot: read position plus offset relative to read offset, mod ring
  assign re    = accept;
  assign raddr = (item_i.opcode == srf_pkg::OpData)
               ? rd_pos_q + item_i.offset[Aw-1:0] - rd_off_q[Aw-1:0]
               : rd_pos_q;

  // ------------------------------------------------------------ exec logic
  logic present;
  assign present = rdata[8];

  always_comb begin
    rd_off_d = rd_off_q;  rd_pos_d = rd_pos_q;  high_d = high_q;
    fsize_d = fsize_q;    fknown_d = fknown_q;  rst_seen_d = rst_seen_q;
    done_d = done_q;      perr_d = perr_q;      fopen_d = fopen_q;
    fend_d = fend_q;      st_d = st_q;          rbyte_d = rbyte_q;
    aerr_d = aerr_q;      raise_d = raise_q;    with_s_d = with_s_q;
    we = 1'b0;  waddr = pos_q;  wdata = '0;

    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (state_q == S_EXEC) begin
      st_d = srf_pkg::StOk;  rbyte_d = '0;  aerr_d = '0;
      raise_d = 1'b0;  with_s_d = 1'b0;
      case (it_q.opcode)
        srf_pkg::OpHeader: begin
          fopen_d = 1'b0;
          if ((fknown_q && (end_q > fsize_q || (it_q.fin && end_q != fsize_q)))
              || (it_q.fin && end_q < high_q)) begin
            st_d = srf_pkg::StFinalSize;
          end else if (end_q > s_cred_q) begin
            st_d = srf_pkg::StFlow;
          end else if (end_q > high_q && end_q > c_cred_q) begin
            high_d = end_q;  // growth stays even though the frame fails
            st_d   = srf_pkg::StFlow;
          end else begin
            if (end_q > high_q) high_d = end_q;
            if (it_q.fin) begin
              fsize_d = end_q;  fknown_d = 1'b1;
            end
            if (!(rst_seen_q || done_q || end_q <= rd_off_q)) begin
              fopen_d = 1'b1;  fend_d = end_q;
            end
          end
        end
        srf_pkg::OpData: begin
          if (!fopen_q || rst_seen_q || done_q || {2'b00, it_q.offset} >= fend_q
              || off_lt_rd_q || rel_big_q) begin
            st_d = srf_pkg::StIgnored;
          end else if (!present) begin
            we = 1'b1;  wdata = {1'b1, it_q.data_byte};
          end
        end
        srf_pkg::OpRead: begin
          if (rst_seen_q) begin
            st_d = srf_pkg::StReset;  aerr_d = perr_q;  done_d = 1'b1;
          end else if (done_q) begin
            st_d = srf_pkg::StEnd;
          end else if (present) begin
            rbyte_d  = rdata[7:0];
            we       = 1'b1;
            rd_pos_d = rd_pos_q + 1'b1;
            rd_off_d = rd_off_q + 1'b1;
            raise_d  = 1'b1;  with_s_d = 1'b1;
          end else if (fknown_q && fsize_q == rd_off_q) begin
            st_d = srf_pkg::StEnd;  done_d = 1'b1;
          end else begin
            st_d = srf_pkg::StNoData;
          end
        end
        srf_pkg::OpReset: begin
          fopen_d = 1'b0;
          if ((fknown_q && end_q != fsize_q) || end_q < high_q) begin
            st_d = srf_pkg::StFinalSize;
          end else if (end_q > s_cred_q) begin
            st_d = srf_pkg::StFlow;
          end else if (end_q > high_q && end_q > c_cred_q) begin
            high_d = end_q;
            st_d   = srf_pkg::StFlow;
          end else begin
            if (end_q > high_q) high_d = end_q;
            fsize_d = end_q;  fknown_d = 1'b1;
            // Ring contents are never looked at again once reset is seen,
            // so the buffered bytes are dropped without a clearing pass.
            if (!(rst_seen_q || done_q)) begin
              rst_seen_d = 1'b1;  perr_d = it_q.error_code;
              rd_off_d = end_q;   raise_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ credit raise
  logic [W-1:0] c_nl, s_nl;
  logic         c_go, s_go;
  assign c_nl = rd_off_q + W'(win.conn_window);
  assign s_nl = rd_off_q + W'(win.stream_window);
  assign c_go = raise_q && c_nl > c_cred_q
             && (c_nl - c_cred_q) >= W'(win.conn_window[20:1]);
  assign s_go = raise_q && with_s_q && !fknown_q && s_nl > s_cred_q
             && (s_nl - s_cred_q) >= W'(win.stream_window[12:1]);
  assign c_cred_d = c_go ? c_nl : c_cred_q;
  assign s_cred_d = s_go ? s_nl : s_cred_q;

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == Aw'(srf_pkg::RingBytes - 1)) state_d = S_IDLE;
      S_IDLE:   if (start_i) state_d = S_CALC;
      S_CALC:   state_d = S_EXEC;
      S_EXEC:   state_d = S_CREDIT;
      S_CREDIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;     clr_q <= '0;
      rd_off_q <= '0;         rd_pos_q <= '0;
      high_q <= '0;           fsize_q <= '0;       fknown_q <= 1'b0;
      s_cred_q <= W'(srf_pkg::StreamWindowRst);
      c_cred_q <= W'(srf_pkg::ConnWindowRst);
      rst_seen_q <= 1'b0;     done_q <= 1'b0;      perr_q <= '0;
      fopen_q <= 1'b0;        fend_q <= '0;
      raise_q <= 1'b0;        with_s_q <= 1'b0;    valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      rd_off_q <= rd_off_d;   rd_pos_q <= rd_pos_d;
      high_q <= high_d;       fsize_q <= fsize_d;  fknown_q <= fknown_d;
      rst_seen_q <= rst_seen_d;  done_q <= done_d; perr_q <= perr_d;
      fopen_q <= fopen_d;     fend_q <= fend_d;
      raise_q <= raise_d;     with_s_q <= with_s_d;
      if (state_q == S_CREDIT) begin
        s_cred_q <= s_cred_d;  c_cred_q <= c_cred_d;
      end
      valid_q <= (state_q == S_CREDIT);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_q  <= item_i;
      pos_q <= raddr;
    end
    if (state_q == S_CALC) begin
      end_q       <= (it_q.opcode == srf_pkg::OpHeader)
                   ? {2'b00, it_q.offset} + W'(it_q.length)
                   : {2'b00, it_q.offset};
      off_lt_rd_q <= {2'b00, it_q.offset} < rd_off_q;
      rel_big_q   <= ({2'b00, it_q.offset} - rd_off_q) >= W'(srf_pkg::RingBytes);
    end
    st_q <= st_d;  rbyte_q <= rbyte_d;  aerr_q <= aerr_d;
    if (state_q == S_CREDIT) begin
      res_q.status              <= st_q;
      res_q.read_byte           <= rbyte_q;
      res_q.app_error           <= aerr_q;
      res_q.stream_limit        <= s_cred_d[61:0];
      res_q.stream_limit_raised <= s_go;
      res_q.conn_limit_out      <= c_cred_d[61:0];
      res_q.conn_limit_raised   <= c_go;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_res_after_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == S_CREDIT)
    else $error("result strobe without credit step");
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == S_CALC)
    else $error("accepted transfer did not start");
  a_no_ring_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_CALC) |-> !we)
    else $error("ring written outside clear or exec");
  a_rd_off_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && it_q.opcode == srf_pkg::OpRead && st_d == srf_pkg::StOk)
    |=> rd_off_q == $past(rd_off_q) + 1'b1)
    else $error("read offset did not advance on pop");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the stream receive reassembly block: predictor, driver, monitor, checks.
module tb_top;

  localparam int unsigned Depth     = 4096;
  localparam int unsigned PhaseLen  = 280;
  localparam int unsigned SettleCyc = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  srf_pkg::item_t item_i;
  logic res_valid_o;
  srf_pkg::result_t res_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  stream_rx_reassembly_flow_control dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // pending items, results still owed by the block
  srf_pkg::item_t   pend_q[$];
  srf_pkg::result_t owed_q[$];
  int      fails = 0;
  bit      no_idle = 1'b0;

  // predictor copy of the stream state
  logic [63:0] win_s, win_c;
  logic [63:0] rd_off, hi_off, fin_size, s_cred, c_cred, peer_err, fr_end;
  logic [11:0] rd_pos;
  bit          fin_known, rst_seen, done, fr_open, s_up, c_up;
  logic [7:0]  ring_m [Depth];
  bit          full_m [Depth];

  initial begin
    win_s = 64'd4096; win_c = 64'd65536;
    rd_off = '0; hi_off = '0; fin_size = '0; peer_err = '0; fr_end = '0;
    rd_pos = '0; fin_known = 0; rst_seen = 0; done = 0; fr_open = 0;
    s_cred = win_s; c_cred = win_c;
    for (int i = 0; i < Depth; i++) begin
      ring_m[i] = '0;
      full_m[i] = 0;
    end
  end

  // grow the highest offset; flow error if it breaks a credit limit
  function automatic logic [2:0] grow_high(logic [63:0] e);
    if (e > s_cred) return srf_pkg::StFlow;
    if (e > hi_off) begin
      hi_off = e;
      if (hi_off > c_cred) return srf_pkg::StFlow;
    end
    return srf_pkg::StOk;
  endfunction

  // half-window credit update after consumption
  function automatic void bump_credit(bit with_stream);
    logic [63:0] nl;
    nl = rd_off + win_c;
    if (nl > c_cred && nl - c_cred >= (win_c >> 1)) begin
      c_cred = nl;
      c_up = 1;
    end
    if (!with_stream || fin_known) return;
    nl = rd_off + win_s;
    if (nl > s_cred && nl - s_cred >= (win_s >> 1)) begin
      s_cred = nl;
      s_up = 1;
    end
  endfunction

  function automatic srf_pkg::result_t stream_response(srf_pkg::item_t it);
    srf_pkg::result_t r;
    logic [63:0] off, e, rel;
    logic [11:0] pos;
    r = '0;
    s_up = 0;
    c_up = 0;
    off = {2'b00, it.offset};
    case (it.opcode)
      srf_pkg::OpHeader: begin
        e = off + {48'd0, it.length};
        fr_open = 0;
        if (fin_known && (e > fin_size || (it.fin && e != fin_size)))
          r.status = srf_pkg::StFinalSize;
        else if (it.fin && e < hi_off) r.status = srf_pkg::StFinalSize;
        else begin
          r.status = grow_high(e);
          if (r.status == srf_pkg::StOk) begin
            if (it.fin) begin
              fin_size = e;
              fin_known = 1;
            end
            if (!(rst_seen || done || e <= rd_off)) begin
              fr_open = 1;
              fr_end = e;
            end
          end
        end
      end
      srf_pkg::OpData: begin
        if (!fr_open || rst_seen || done || off >= fr_end || off < rd_off)
          r.status = srf_pkg::StIgnored;
        else begin
          rel = off - rd_off;
          if (rel >= 64'(Depth)) r.status = srf_pkg::StIgnored;
          else begin
            pos = rd_pos + rel[11:0];
            if (!full_m[pos]) begin
              ring_m[pos] = it.data_byte;
              full_m[pos] = 1;
            end
            r.status = srf_pkg::StOk;
          end
        end
      end
      srf_pkg::OpRead: begin
        if (rst_seen) begin
          r.app_error = peer_err[61:0];
          done = 1;
          r.status = srf_pkg::StReset;
        end else if (done) r.status = srf_pkg::StEnd;
        else if (full_m[rd_pos]) begin
          r.read_byte = ring_m[rd_pos];
          ring_m[rd_pos] = '0;
          full_m[rd_pos] = 0;
          rd_pos = rd_pos + 12'd1;
          rd_off = rd_off + 64'd1;
          bump_credit(1'b1);
          r.status = srf_pkg::StOk;
        end else if (fin_known && fin_size == rd_off) begin
          done = 1;
          r.status = srf_pkg::StEnd;
        end else r.status = srf_pkg::StNoData;
      end
      default: begin
        fr_open = 0;
        if ((fin_known && off != fin_size) || off < hi_off) r.status = srf_pkg::StFinalSize;
        else begin
          r.status = grow_high(off);
          if (r.status == srf_pkg::StOk) begin
            fin_size = off;
            fin_known = 1;
            if (!(rst_seen || done)) begin
              rst_seen = 1;
              peer_err = {2'b00, it.error_code};
              for (int i = 0; i < Depth; i++) begin
                ring_m[i] = '0;
                full_m[i] = 0;
              end
              rd_off = off;
              bump_credit(1'b0);
            end
          end
        end
      end
    endcase
    r.stream_limit        = s_cred[61:0];
    r.stream_limit_raised = s_up;
    r.conn_limit_out      = c_cred[61:0];
    r.conn_limit_raised   = c_up;
    return r;
  endfunction

  // driver: predicts on each accepted transfer, then offers the next item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
    end else begin
      if (start_i && !busy_o) owed_q.push_back(stream_response(item_i));
      if (!(start_i && busy_o)) begin
        if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
          item_i  <= pend_q.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, actual %0h", name, e, a);
      fails++;
    end
  endtask

  // monitor: each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    srf_pkg::result_t e;
    if (rst_ni && res_valid_o) begin
      if (owed_q.size() == 0) begin
        $error("result with no transfer outstanding");
        fails++;
      end else begin
        e = owed_q.pop_front();
        check_field("status", 64'(e.status), 64'(res_o.status));
        check_field("read_byte", 64'(e.read_byte), 64'(res_o.read_byte));
        check_field("app_error", 64'(e.app_error), 64'(res_o.app_error));
        check_field("stream_limit", 64'(e.stream_limit), 64'(res_o.stream_limit));
        check_field("stream_limit_raised", 64'(e.stream_limit_raised),
                    64'(res_o.stream_limit_raised));
        check_field("conn_limit_out", 64'(e.conn_limit_out), 64'(res_o.conn_limit_out));
        check_field("conn_limit_raised", 64'(e.conn_limit_raised),
                    64'(res_o.conn_limit_raised));
      end
    end
  end

  function automatic srf_pkg::item_t mk(logic [1:0] op, logic [63:0] off, logic [15:0] len,
                                        bit fin, logic [7:0] b);
    srf_pkg::item_t it;
    it.opcode     = op;
    it.offset     = off[61:0];
    it.length     = len;
    it.fin        = fin;
    it.data_byte  = b;
    it.error_code = 62'({$urandom, $urandom});
    return it;
  endfunction

  function automatic srf_pkg::item_t noise_item();
    srf_pkg::item_t it;
    it = mk(2'($urandom_range(2)), {$urandom, $urandom}, 16'($urandom), 1'($urandom),
            8'($urandom));
    if (it.opcode == srf_pkg::OpHeader && it.fin) it.offset[61] = 1'b1;  // never sets final size
    if (it.opcode == srf_pkg::OpData && $urandom_range(1))
      it.offset = rd_off[61:0] + 62'($urandom_range(20));
    return it;
  endfunction

  task automatic apb_write(logic [2:0] a, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == srf_pkg::AddrStreamWindow) win_s = {51'd0, d[12:0]};
    else win_c = {43'd0, d[20:0]};
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (!(pend_q.size() == 0 && !start_i && owed_q.size() == 0));
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // one frame: header, its bytes in random order with repeats and noise items, then reads
  task automatic frame_burst(int maxlen);
    logic [63:0] o;
    int n;
    int idx[$];
    int k;
    o = rd_off + 64'($urandom_range(3));
    if ($urandom_range(3) == 0 && o >= 2) o = o - 64'($urandom_range(2));
    n = $urandom_range(maxlen, 1);
    pend_q.push_back(mk(srf_pkg::OpHeader, o, 16'(n), 1'b0, 8'($urandom)));
    for (int i = 0; i < n; i++) idx.push_back(i);
    while (idx.size() != 0) begin
      k = $urandom_range(idx.size() - 1);
      pend_q.push_back(mk(srf_pkg::OpData, o + 64'(idx[k]), '0, 1'($urandom), 8'($urandom)));
      if ($urandom_range(7) == 0)
        pend_q.push_back(mk(srf_pkg::OpData, o + 64'(idx[k]), '0, 1'b0, 8'($urandom)));
      idx.delete(k);
      if ($urandom_range(5) == 0) pend_q.push_back(noise_item());
    end
    repeat ($urandom_range(n + 2, 1)) pend_q.push_back(mk(srf_pkg::OpRead, '0, '0, 1'b0, '0));
  endtask

  initial begin
    logic [31:0] ws, cs;
    int gen;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_write(srf_pkg::AddrStreamWindow, 32'd4096);
    apb_write(srf_pkg::AddrConnWindow, 32'd65536);

    // directed: in-order and out-of-order bytes, repeats, out-of-frame, errors
    pend_q.push_back(mk(srf_pkg::OpHeader, 64'd0, 16'd4, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd0, '0, 1'b0, 8'h00));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd1, '0, 1'b0, 8'hFF));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd1, '0, 1'b0, 8'h11));  // spot taken, first copy stays
    pend_q.push_back(mk(srf_pkg::OpData, 64'd3, '0, 1'b0, 8'h5A));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd2, '0, 1'b0, 8'hA5));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd4, '0, 1'b0, 8'h77));  // past frame end
    repeat (5) pend_q.push_back(mk(srf_pkg::OpRead, '0, '0, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpHeader, 64'd0, 16'd2, 1'b0, '0));  // retransmission
    pend_q.push_back(mk(srf_pkg::OpData, 64'd1, '0, 1'b0, 8'h33));
    pend_q.push_back(mk(srf_pkg::OpHeader, 64'd4000, 16'd200, 1'b0, '0));  // over stream credit
    pend_q.push_back(mk(srf_pkg::OpHeader, {2'b00, {62{1'b1}}}, 16'hFFFF, 1'b1, '0));
    pend_q.push_back(mk(srf_pkg::OpHeader, 64'd2, 16'd0, 1'b1, '0));  // final below highest
    pend_q.push_back(mk(srf_pkg::OpData, 64'd4, '0, 1'b0, 8'h44));  // no frame open
    pend_q.push_back(mk(srf_pkg::OpHeader, 64'd4, 16'd1, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpData, 64'd4, '0, 1'b0, 8'h99));
    pend_q.push_back(mk(srf_pkg::OpRead, '0, '0, 1'b0, '0));
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin ws = 32'd4096; cs = 32'd65536; end
        1: begin ws = 32'd1;    cs = 32'd1;     end
        2: begin ws = 32'd4096; cs = 32'd1048576; end
        3: begin ws = 32'($urandom_range(4096, 2)); cs = 32'($urandom_range(1048576, 2)); end
        default: begin ws = 32'($urandom_range(64, 1)); cs = 32'($urandom_range(4096, 1)); end
      endcase
      apb_write(srf_pkg::AddrStreamWindow, ws);
      apb_write(srf_pkg::AddrConnWindow, cs);
      no_idle = (ph == 2);
      gen = 0;
      while (gen < PhaseLen) begin
        // new frames are built from the current read offset, so let the queue drain
        do @(negedge clk_i); while (pend_q.size() != 0);
        if ($urandom_range(9) == 0) pend_q.push_back(noise_item());
        else frame_burst((ws < 12) ? int'(ws) + 1 : 12);
        gen += pend_q.size();
      end
      wait_idle();  // sender holds off until every result is in
    end
    no_idle = 1'b0;

    // stream reset: bad sizes, then the real one, then traffic after it
    apb_write(srf_pkg::AddrStreamWindow, 32'd4096);
    apb_write(srf_pkg::AddrConnWindow, 32'd65536);
    if (hi_off != 0) pend_q.push_back(mk(srf_pkg::OpReset, hi_off - 64'd1, '0, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpReset, {2'b00, {62{1'b1}}}, '0, 1'b0, '0));
    wait_idle();
    pend_q.push_back(mk(srf_pkg::OpReset, hi_off, '0, 1'b0, '0));
    repeat (3) pend_q.push_back(mk(srf_pkg::OpRead, '0, '0, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpHeader, hi_off, 16'd0, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpData, hi_off, '0, 1'b0, 8'h12));
    pend_q.push_back(mk(srf_pkg::OpReset, hi_off, '0, 1'b0, '0));
    pend_q.push_back(mk(srf_pkg::OpReset, hi_off + 64'd1, '0, 1'b0, '0));
    repeat (20) pend_q.push_back(noise_item());
    pend_q.push_back(mk(srf_pkg::OpRead, '0, '0, 1'b0, '0));

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fails == 0 && owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
